[hdl/rca_pkg.sv]
// Shared types and constants for the RSA cyclic attack engine.
// Used by the controller, the datapath, the modular multiplier, the top level and the checker.
package rca_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FIELD_BITS = 32;
    localparam int CNT_W      = $clog2(WORD_BITS);
    localparam int ADDR_W     = 4;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [WORD_BITS:0]    ext_t;
    typedef logic [FIELD_BITS-1:0] field_t;

    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_MODULUS    = 2'd0;
    localparam reg_index_t REG_EXPONENT   = 2'd1;
    localparam reg_index_t REG_STEP_LIMIT = 2'd2;

    localparam field_t MODULUS_RESET    = 32'd2;
    localparam field_t EXPONENT_RESET   = 32'd1;
    localparam field_t STEP_LIMIT_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_RANGE = 2'd1,
        ST_LIMIT = 2'd2
    } status_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_POW_INIT,
        S_POW_TEST,
        S_MUL_ACC,
        S_SQ_TEST,
        S_MUL_SQ,
        S_STEP_END,
        S_FINISH
    } rca_state_t;

    typedef struct packed {
        logic         load;
        logic         pow_init;
        logic         mul_start;
        logic         sel_sq;
        logic         acc_write;
        logic         sq_write;
        logic         e_shift;
        logic         step_commit;
        logic         set_result;
        status_code_t result_code;
        logic         out_load;
    } rca_cmd_t;

    typedef struct packed {
        logic range_ok;
        logic limit_hit;
        logic e_zero;
        logic e_bit0;
        logic e_rest_zero;
        logic mul_done;
        logic match;
    } rca_status_t;

endpackage

[hdl/rca_modmul.sv]
// Bit-serial modular multiplier: r = a * b mod n, one add-and-reduce per cycle.
// Depends on rca_pkg.
module rca_modmul (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  rca_pkg::word_t op_a,
    input  rca_pkg::word_t op_b,
    input  rca_pkg::word_t modulus,
    output logic          done,
    output rca_pkg::word_t result
);
    import rca_pkg::*;

    word_t            r_reg, r_next;
    word_t            a_reg, a_next;
    word_t            b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             phase_reg, phase_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    word_t addend;
    ext_t  sum;
    ext_t  reduced;

    // Phase 0 doubles the partial result, phase 1 adds a when the current bit of b is set.
    // Both operands stay below n, so one conditional subtract keeps the sum reduced.
    always_comb begin
        if (phase_reg) begin
            addend = b_reg[WORD_BITS-1] ? a_reg : '0;
        end else begin
            addend = r_reg;
        end
        sum     = {1'b0, r_reg} + {1'b0, addend};
        reduced = (sum >= {1'b0, modulus}) ? (sum - {1'b0, modulus}) : sum;
    end

    always_comb begin
        r_next     = r_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            r_next     = '0;
            a_next     = op_a;
            b_next     = op_b;
            cnt_next   = '0;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            r_next     = reduced[WORD_BITS-1:0];
            phase_next = ~phase_reg;
            if (phase_reg) begin
                b_next   = {b_reg[WORD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_BITS-1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        r_reg     <= r_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

[hdl/rca_datapath.sv]
// Datapath: ciphertext, current value, power accumulators, step count and result registers.
// Depends on rca_pkg and rca_modmul; driven by rca_ctrl commands.
module rca_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  rca_pkg::field_t    s_ciphertext,
    input  rca_pkg::field_t    cfg_modulus,
    input  rca_pkg::field_t    cfg_exponent,
    input  rca_pkg::field_t    cfg_step_limit,
    input  rca_pkg::rca_cmd_t  cmd,
    output rca_pkg::rca_status_t stat,
    output rca_pkg::field_t    m_plaintext,
    output rca_pkg::field_t    m_steps_taken,
    output logic [1:0]         m_status
);
    import rca_pkg::*;

    word_t        c_reg;
    word_t        prev_reg;
    word_t        acc_reg;
    word_t        sq_reg;
    word_t        e_reg;
    field_t       steps_reg;
    status_code_t code_reg;
    field_t       out_plain_reg;
    field_t       out_steps_reg;
    status_code_t out_status_reg;

    word_t n_w;
    word_t e_w;
    word_t mul_a;
    word_t mul_result;
    logic  mul_done;

    assign n_w   = word_t'(cfg_modulus);
    assign e_w   = word_t'(cfg_exponent);
    assign mul_a = cmd.sel_sq ? sq_reg : acc_reg;

    rca_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (sq_reg),
        .modulus (n_w),
        .done    (mul_done),
        .result  (mul_result)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            c_reg     <= word_t'(s_ciphertext);
            prev_reg  <= word_t'(s_ciphertext);
            steps_reg <= '0;
        end
        if (cmd.pow_init) begin
            // A modulus of one reduces the empty product to zero.
            acc_reg <= (n_w == word_t'(1)) ? '0 : word_t'(1);
            sq_reg  <= prev_reg;
            e_reg   <= e_w;
        end
        if (cmd.acc_write) begin
            acc_reg <= mul_result;
        end
        if (cmd.sq_write) begin
            sq_reg <= mul_result;
        end
        if (cmd.e_shift) begin
            e_reg <= e_reg >> 1;
        end
        if (cmd.step_commit) begin
            steps_reg <= steps_reg + 1'b1;
            if (acc_reg != c_reg) begin
                prev_reg <= acc_reg;
            end
        end
        if (cmd.set_result) begin
            code_reg <= cmd.result_code;
        end
        if (cmd.out_load) begin
            out_plain_reg  <= (code_reg == ST_FOUND) ? field_t'(prev_reg) : '0;
            out_steps_reg  <= steps_reg;
            out_status_reg <= code_reg;
        end
    end

    always_comb begin
        stat.range_ok    = c_reg < n_w;
        stat.limit_hit   = steps_reg == cfg_step_limit;
        stat.e_zero      = e_reg == '0;
        stat.e_bit0      = e_reg[0];
        stat.e_rest_zero = e_reg[WORD_BITS-1:1] == '0;
        stat.mul_done    = mul_done;
        stat.match       = acc_reg == c_reg;
    end

    assign m_plaintext   = out_plain_reg;
    assign m_steps_taken = out_steps_reg;
    assign m_status      = out_status_reg;

endmodule

[hdl/rca_ctrl.sv]
// Controller: sequences the cycle search, square-and-multiply steps and the result handshake.
// Depends on rca_pkg; commands go to rca_datapath.
module rca_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rca_pkg::rca_status_t stat,
    output rca_pkg::rca_cmd_t    cmd
);
    import rca_pkg::*;

    rca_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (!stat.range_ok || stat.limit_hit) state_next = S_FINISH;
                else state_next = S_POW_INIT;
            end
            S_POW_INIT: state_next = S_POW_TEST;
            S_POW_TEST: begin
                if (stat.e_zero) state_next = S_STEP_END;
                else if (stat.e_bit0) state_next = S_MUL_ACC;
                else state_next = S_SQ_TEST;
            end
            S_MUL_ACC: begin
                if (stat.mul_done) state_next = S_SQ_TEST;
            end
            S_SQ_TEST: begin
                if (stat.e_rest_zero) state_next = S_POW_TEST;
                else state_next = S_MUL_SQ;
            end
            S_MUL_SQ: begin
                if (stat.mul_done) state_next = S_POW_TEST;
            end
            S_STEP_END: begin
                if (stat.match) state_next = S_FINISH;
                else state_next = S_CHECK;
            end
            S_FINISH: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.result_code = ST_FOUND;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_CHECK: begin
                cmd.set_result = !stat.range_ok || stat.limit_hit;
                cmd.result_code = stat.range_ok ? ST_LIMIT : ST_RANGE;
            end
            S_POW_INIT: cmd.pow_init = 1'b1;
            S_POW_TEST: begin
                cmd.mul_start = !stat.e_zero && stat.e_bit0;
            end
            S_MUL_ACC: cmd.acc_write = stat.mul_done;
            S_SQ_TEST: begin
                cmd.e_shift   = 1'b1;
                cmd.mul_start = !stat.e_rest_zero;
                cmd.sel_sq    = 1'b1;
            end
            S_MUL_SQ: cmd.sq_write = stat.mul_done;
            S_STEP_END: begin
                cmd.step_commit = 1'b1;
                cmd.set_result  = stat.match;
                cmd.result_code = ST_FOUND;
            end
            S_FINISH: cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[hdl/rsa_cyclic_attack_engine_core.sv]
// RSA cyclic attack engine: top level with the APB register file.
// Depends on rca_pkg, rca_ctrl and rca_datapath.
//
// Usage: program modulus (0x0), public_exponent (0x4) and step_limit (0x8) over the
// APB port while the block is idle; pready is always high and reads return the values.
// Each transaction on the s_ channel carries one ciphertext. The block re-encrypts the
// current value until it returns to the ciphertext and delivers one transaction on the
// m_ channel with the plaintext, the number of exponentiations and a status code.
// An out-of-range ciphertext or a zero step limit ends the item before any
// exponentiation. Otherwise each exponentiation runs square-and-multiply over the
// exponent bits, and every modular multiplication passes through the bit-serial
// multiplier, which doubles and conditionally adds once per bit of the word and then
// hands back the product.
// One item is processed at a time; s_ready is high only between items.
// A finished result sits in the output register; the next ciphertext is accepted while
// it waits. If the receiver stalls, the following result waits until m_ready frees it.
// Reset clears the controller and output valid and restores the register defaults
// (modulus 2, exponent 1, step limit all ones).
module rsa_cyclic_attack_engine_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rca_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rca_pkg::field_t            s_ciphertext,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rca_pkg::field_t            m_plaintext,
    output rca_pkg::field_t            m_steps_taken,
    output logic [1:0]                 m_status
);
    import rca_pkg::*;

    field_t      modulus_reg;
    field_t      exponent_reg;
    field_t      step_limit_reg;
    reg_index_t  reg_index;
    logic        cfg_write;
    rca_cmd_t    cmd;
    rca_status_t stat;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg    <= MODULUS_RESET;
            exponent_reg   <= EXPONENT_RESET;
            step_limit_reg <= STEP_LIMIT_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                REG_MODULUS:    modulus_reg    <= pwdata;
                REG_EXPONENT:   exponent_reg   <= pwdata;
                REG_STEP_LIMIT: step_limit_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_MODULUS:    prdata = modulus_reg;
            REG_EXPONENT:   prdata = exponent_reg;
            REG_STEP_LIMIT: prdata = step_limit_reg;
            default:        prdata = '0;
        endcase
    end

    rca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rca_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_ciphertext   (s_ciphertext),
        .cfg_modulus    (modulus_reg),
        .cfg_exponent   (exponent_reg),
        .cfg_step_limit (step_limit_reg),
        .cmd            (cmd),
        .stat           (stat),
        .m_plaintext    (m_plaintext),
        .m_steps_taken  (m_steps_taken),
        .m_status       (m_status)
    );

endmodule

[hdl/rca_checker.sv]
// Port-level checker for the RSA cyclic attack engine, bound to the top level.
// Depends on rca_pkg and rsa_cyclic_attack_engine_core.
module rca_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input rca_pkg::field_t m_plaintext,
    input rca_pkg::field_t m_steps_taken,
    input logic [1:0]      m_status
);
    import rca_pkg::*;

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_plaintext)
            && $stable(m_steps_taken) && $stable(m_status))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_FOUND || m_status == ST_RANGE || m_status == ST_LIMIT))
        else $error("undefined status code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_FOUND |-> m_plaintext == '0)
        else $error("nonzero plaintext on a failed search");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_RANGE |-> m_steps_taken == '0)
        else $error("steps counted for an out-of-range ciphertext");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result channel not idle after reset");

endmodule

bind rsa_cyclic_attack_engine_core rca_checker u_rca_checker (.*);
